// ----- rtl/sector_cache_tag_and_replacement_assert.svh -----
// ---------------------------------------------------------------------------
// Assertion macros for the sector cache tag and replacement engine
// ---------------------------------------------------------------------------
`ifndef SECTOR_CACHE_TAG_AND_REPLACEMENT_ASSERT_SVH
`define SECTOR_CACHE_TAG_AND_REPLACEMENT_ASSERT_SVH

// Same-cycle implication, disabled during reset
`define SCT_ASSERT_IMP(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("sector cache check failed");

// Next-cycle implication, disabled during reset
`define SCT_ASSERT_NXT(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("sector cache check failed");

`endif

// ----- rtl/scache_pkg.sv -----
// ---------------------------------------------------------------------------
// scache_pkg
// Shared types and constants of the sector cache tag and replacement engine.
// ---------------------------------------------------------------------------
package scache_pkg;

  // Parameter defaults
  localparam int ENTRIES_DEF     = 64;
  localparam int PRIO_LEVELS_DEF = 8;

  // Fixed field widths
  localparam int KIND_W  = 2;
  localparam int DISK_W  = 16;
  localparam int LBA_W   = 32;
  localparam int PREQ_W  = 3;
  localparam int SLOT_W  = 6;
  localparam int HITS_W  = 16;
  localparam int AGE_W   = 16;
  localparam int THR_W   = 16;
  localparam int EIU_W   = 7;
  localparam int CFG_W   = 16;
  localparam int CIDX_W  = 1;

  // Constants
  localparam logic [HITS_W-1:0] HITS_MAX  = 16'hffff;
  localparam logic [THR_W-1:0]  THR_RESET = 16'd4096;
  localparam logic [EIU_W-1:0]  EIU_RESET = 7'd64;

  // Beat kinds
  typedef enum logic [KIND_W-1:0] {
    KIND_ACCESS  = 2'd0,
    KIND_RELEASE = 2'd1,
    KIND_FLUSH   = 2'd2
  } kind_t;

  // Configuration register indexes
  typedef enum logic [CIDX_W-1:0] {
    REG_THRESHOLD = 1'b0,
    REG_ENTRIES   = 1'b1
  } reg_idx_t;

  // Status of one tag scan
  typedef struct packed {
    logic found;
    logic free_found;
  } scan_flags_t;

endpackage

// ----- rtl/scache_ram.sv -----
// ---------------------------------------------------------------------------
// scache_ram
// Entry store: one write port, one read port, registered read data.
// ---------------------------------------------------------------------------
module scache_ram #(
  parameter int DEPTH = 64,
  parameter int WIDTH = 84,
  parameter int AW    = 6
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write entry
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Read entry, registered read data
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ----- rtl/scache_scan.sv -----
// ---------------------------------------------------------------------------
// scache_scan
// Walks the entry stream once: first tag match, first free slot and the
// replacement victim (largest priority, fewest hits, oldest, lowest slot).
// ---------------------------------------------------------------------------
module scache_scan #(
  parameter int IDX_W  = 6,
  parameter int PRIO_W = 3
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              start,
  input  logic                              beat_valid,
  input  logic [IDX_W-1:0]                  beat_idx,
  input  logic                              ent_valid,
  input  logic [scache_pkg::DISK_W-1:0]     ent_disk,
  input  logic [scache_pkg::LBA_W-1:0]      ent_lba,
  input  logic [PRIO_W-1:0]                 ent_prio,
  input  logic [scache_pkg::HITS_W-1:0]     ent_hits,
  input  logic [scache_pkg::AGE_W-1:0]      ent_age,
  input  logic [scache_pkg::DISK_W-1:0]     req_disk,
  input  logic [scache_pkg::LBA_W-1:0]      req_lba,
  output scache_pkg::scan_flags_t           flags,
  output logic [IDX_W-1:0]                  match_idx,
  output logic [PRIO_W-1:0]                 match_prio,
  output logic [scache_pkg::HITS_W-1:0]     match_hits,
  output logic [scache_pkg::AGE_W-1:0]      match_age,
  output logic [IDX_W-1:0]                  free_idx,
  output logic [IDX_W-1:0]                  victim_idx
);

  import scache_pkg::*;

  logic              is_match;
  logic              better;
  logic [PRIO_W-1:0] vic_prio;
  logic [HITS_W-1:0] vic_hits;
  logic [AGE_W-1:0]  vic_age;

  // Compare this beat against the request and the current victim
  always_comb begin
    is_match = ent_valid && (ent_disk == req_disk) && (ent_lba == req_lba);
    better   = (beat_idx == '0) ||
               (ent_prio > vic_prio) ||
               ((ent_prio == vic_prio) &&
                ((ent_hits < vic_hits) ||
                 ((ent_hits == vic_hits) && (ent_age < vic_age))));
  end

  // Track the first hit and the first free slot
  always_ff @(posedge clk) begin
    if (rst || start) begin
      flags <= '0;
    end else if (beat_valid) begin
      if (is_match && !flags.found) begin
        flags.found <= 1'b1;
      end
      if (!ent_valid && !flags.free_found) begin
        flags.free_found <= 1'b1;
      end
    end
  end

  // Capture payload of the hit, the free slot and the running victim
  always_ff @(posedge clk) begin
    if (beat_valid) begin
      if (is_match && !flags.found) begin
        match_idx  <= beat_idx;
        match_prio <= ent_prio;
        match_hits <= ent_hits;
        match_age  <= ent_age;
      end
      if (!ent_valid && !flags.free_found) begin
        free_idx <= beat_idx;
      end
      if (better) begin
        victim_idx <= beat_idx;
        vic_prio   <= ent_prio;
        vic_hits   <= ent_hits;
        vic_age    <= ent_age;
      end
    end
  end

endmodule

// ----- rtl/sector_cache_tag_and_replacement.sv -----
// ---------------------------------------------------------------------------
// sector_cache_tag_and_replacement
// Tag and replacement engine of a fully associative sector cache.
// ---------------------------------------------------------------------------
// Usage:
//   Input beats (kind, disk_id, sector_lba, priority_req, release_slot) are
//   taken on in_valid && in_ready; each beat yields one result beat (hit,
//   slot, replaced, flushed) on out_valid && out_ready.
//   The block works on one beat at a time. An access reads every slot in
//   use from the entry memory, one slot per cycle, then decides and writes
//   the entry back before the result. A miss that reaches the flush
//   threshold first sweeps every slot clear, then allocates slot 0.
//   A release clears the slot if in range; a flush sweeps every slot clear.
//   After reset the entry memory is swept clear with in_ready low;
//   configuration writes are taken at any time.
//   The result sits in an output register; while the receiver stalls, the
//   next beat is still accepted and processed up to its result, which then
//   waits until the output register is free.
//   Configuration: cfg_write with cfg_index 0 sets the flush threshold,
//   index 1 the number of slots in use.
// ---------------------------------------------------------------------------
module sector_cache_tag_and_replacement #(
  parameter int ENTRIES         = scache_pkg::ENTRIES_DEF,
  parameter int PRIORITY_LEVELS = scache_pkg::PRIO_LEVELS_DEF
) (
  input  logic                              clk,
  input  logic                              rst,
  // Configuration
  input  logic                              cfg_write,
  input  logic [scache_pkg::CIDX_W-1:0]     cfg_index,
  input  logic [scache_pkg::CFG_W-1:0]      cfg_data,
  // Request channel
  input  logic                              in_valid,
  output logic                              in_ready,
  input  logic [scache_pkg::KIND_W-1:0]     kind,
  input  logic [scache_pkg::DISK_W-1:0]     disk_id,
  input  logic [scache_pkg::LBA_W-1:0]      sector_lba,
  input  logic [scache_pkg::PREQ_W-1:0]     priority_req,
  input  logic [scache_pkg::SLOT_W-1:0]     release_slot,
  // Result channel
  output logic                              out_valid,
  input  logic                              out_ready,
  output logic                              hit,
  output logic [scache_pkg::SLOT_W-1:0]     slot,
  output logic                              replaced,
  output logic                              flushed
);

  import scache_pkg::*;

  localparam int IDX_W  = $clog2(ENTRIES);
  localparam int PRIO_W = $clog2(PRIORITY_LEVELS);
  localparam int WORD_W = 1 + DISK_W + LBA_W + PRIO_W + HITS_W + AGE_W;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SCAN,
    ST_DECIDE,
    ST_CLEAR,
    ST_COMMIT,
    ST_DONE
  } state_t;

  state_t state;

  // Configuration
  logic [THR_W-1:0]  threshold;
  logic [EIU_W-1:0]  entries_in_use;

  // Sequencer
  logic [IDX_W-1:0]  clr_idx;
  logic              clr_to_commit;
  logic              clr_to_done;
  logic [IDX_W-1:0]  scan_addr;
  logic              issuing;
  logic              rd_pending;
  logic [IDX_W-1:0]  rd_pidx;
  logic [IDX_W-1:0]  last_idx;
  logic [HITS_W-1:0] alloc_counter;

  // Request and pending write
  logic [DISK_W-1:0] req_disk;
  logic [LBA_W-1:0]  req_lba;
  logic [PRIO_W-1:0] req_prio;
  logic [IDX_W-1:0]  wr_addr;
  logic              wr_valid;
  logic [PRIO_W-1:0] wr_prio;
  logic [HITS_W-1:0] wr_hits;
  logic [AGE_W-1:0]  wr_age;

  // Pending result
  logic              res_hit;
  logic [SLOT_W-1:0] res_slot;
  logic              res_replaced;
  logic              res_flushed;

  // Memory ports
  logic              mem_we;
  logic [IDX_W-1:0]  mem_waddr;
  logic [WORD_W-1:0] mem_wdata;
  logic              mem_re;
  logic [WORD_W-1:0] mem_rdata;
  logic              rd_valid;
  logic [DISK_W-1:0] rd_disk;
  logic [LBA_W-1:0]  rd_lba;
  logic [PRIO_W-1:0] rd_prio;
  logic [HITS_W-1:0] rd_hits;
  logic [AGE_W-1:0]  rd_age;

  // Scan results
  scan_flags_t       sflags;
  logic [IDX_W-1:0]  match_idx;
  logic [PRIO_W-1:0] match_prio;
  logic [HITS_W-1:0] match_hits;
  logic [AGE_W-1:0]  match_age;
  logic [IDX_W-1:0]  free_idx;
  logic [IDX_W-1:0]  victim_idx;

  // Request decode
  logic              accept;
  logic [EIU_W-1:0]  eiu_m1;
  logic [IDX_W-1:0]  last_calc;
  logic [PRIO_W-1:0] prio_sat;
  logic              rel_ok;
  logic [HITS_W-1:0] hits_inc;
  logic [IDX_W-1:0]  alloc_addr;

  assign in_ready = (state == ST_IDLE);
  assign accept   = in_valid && in_ready;

  // Clamp slot count, saturate priority, range-check release
  always_comb begin
    eiu_m1    = (entries_in_use == '0) ? '0 : entries_in_use - 7'd1;
    last_calc = (32'(eiu_m1) >= ENTRIES - 1) ? IDX_W'(ENTRIES - 1) : IDX_W'(eiu_m1);
    prio_sat  = (32'(priority_req) >= PRIORITY_LEVELS) ?
                PRIO_W'(PRIORITY_LEVELS - 1) : PRIO_W'(priority_req);
    rel_ok    = 32'(release_slot) < ENTRIES;
    hits_inc  = (match_hits == HITS_MAX) ? HITS_MAX : match_hits + 16'd1;
    alloc_addr = sflags.free_found ? free_idx : victim_idx;
  end

  // Memory port steering
  always_comb begin
    mem_we    = (state == ST_CLEAR) || (state == ST_COMMIT);
    mem_waddr = (state == ST_CLEAR) ? clr_idx : wr_addr;
    mem_wdata = (state == ST_CLEAR) ? '0 :
                {wr_valid, req_disk, req_lba, wr_prio, wr_hits, wr_age};
    mem_re    = (state == ST_SCAN) && issuing;
  end

  assign {rd_valid, rd_disk, rd_lba, rd_prio, rd_hits, rd_age} = mem_rdata;

  scache_ram #(
    .DEPTH (ENTRIES),
    .WIDTH (WORD_W),
    .AW    (IDX_W)
  ) u_ram (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .re    (mem_re),
    .raddr (scan_addr),
    .rdata (mem_rdata)
  );

  scache_scan #(
    .IDX_W  (IDX_W),
    .PRIO_W (PRIO_W)
  ) u_scan (
    .clk        (clk),
    .rst        (rst),
    .start      (accept),
    .beat_valid (rd_pending),
    .beat_idx   (rd_pidx),
    .ent_valid  (rd_valid),
    .ent_disk   (rd_disk),
    .ent_lba    (rd_lba),
    .ent_prio   (rd_prio),
    .ent_hits   (rd_hits),
    .ent_age    (rd_age),
    .req_disk   (req_disk),
    .req_lba    (req_lba),
    .flags      (sflags),
    .match_idx  (match_idx),
    .match_prio (match_prio),
    .match_hits (match_hits),
    .match_age  (match_age),
    .free_idx   (free_idx),
    .victim_idx (victim_idx)
  );

  // Sequencer, configuration and output register
  always_ff @(posedge clk) begin
    if (rst) begin
      state          <= ST_CLEAR;
      clr_idx        <= '0;
      clr_to_commit  <= 1'b0;
      clr_to_done    <= 1'b0;
      issuing        <= 1'b0;
      rd_pending     <= 1'b0;
      alloc_counter  <= '0;
      threshold      <= THR_RESET;
      entries_in_use <= EIU_RESET;
      out_valid      <= 1'b0;
    end else begin
      // Take configuration writes
      if (cfg_write) begin
        case (reg_idx_t'(cfg_index))
          REG_THRESHOLD: threshold      <= cfg_data;
          REG_ENTRIES:   entries_in_use <= cfg_data[EIU_W-1:0];
          default: ;
        endcase
      end

      // Drop the result once taken, unless the next one is handed over
      if (out_ready && (state != ST_DONE)) begin
        out_valid <= 1'b0;
      end

      // Follow each issued read in the next cycle
      rd_pending <= (state == ST_SCAN) && issuing;

      case (state)
        ST_IDLE: begin
          if (accept) begin
            req_disk     <= disk_id;
            req_lba      <= sector_lba;
            req_prio     <= prio_sat;
            res_hit      <= 1'b0;
            res_slot     <= '0;
            res_replaced <= 1'b0;
            res_flushed  <= 1'b0;
            case (kind_t'(kind))
              KIND_ACCESS: begin
                last_idx  <= last_calc;
                scan_addr <= '0;
                issuing   <= 1'b1;
                state     <= ST_SCAN;
              end
              KIND_RELEASE: begin
                wr_addr  <= IDX_W'(release_slot);
                wr_valid <= 1'b0;
                wr_prio  <= '0;
                wr_hits  <= '0;
                wr_age   <= '0;
                res_slot <= release_slot;
                state    <= rel_ok ? ST_COMMIT : ST_DONE;
              end
              KIND_FLUSH: begin
                alloc_counter <= '0;
                res_flushed   <= 1'b1;
                clr_idx       <= '0;
                clr_to_commit <= 1'b0;
                clr_to_done   <= 1'b1;
                state         <= ST_CLEAR;
              end
              default: begin
                state <= ST_DONE;
              end
            endcase
          end
        end

        ST_SCAN: begin
          // Issue one read per cycle, follow the data in the cycle after
          if (issuing) begin
            rd_pidx <= scan_addr;
            if (scan_addr == last_idx) begin
              issuing <= 1'b0;
            end else begin
              scan_addr <= scan_addr + 1'b1;
            end
          end
          if (rd_pending && (rd_pidx == last_idx)) begin
            state <= ST_DECIDE;
          end
        end

        ST_DECIDE: begin
          wr_valid <= 1'b1;
          if (sflags.found) begin
            // Hit: bump the access count
            wr_addr  <= match_idx;
            wr_prio  <= match_prio;
            wr_hits  <= hits_inc;
            wr_age   <= match_age;
            res_hit  <= 1'b1;
            res_slot <= SLOT_W'(match_idx);
            state    <= ST_COMMIT;
          end else begin
            wr_prio <= req_prio;
            wr_hits <= 16'd1;
            if (alloc_counter >= threshold) begin
              // Flush everything, then allocate the first slot
              wr_addr       <= '0;
              wr_age        <= '0;
              alloc_counter <= 16'd1;
              res_flushed   <= 1'b1;
              res_slot      <= '0;
              clr_idx       <= '0;
              clr_to_commit <= 1'b1;
              clr_to_done   <= 1'b0;
              state         <= ST_CLEAR;
            end else begin
              wr_addr       <= alloc_addr;
              wr_age        <= alloc_counter;
              alloc_counter <= alloc_counter + 16'd1;
              res_replaced  <= !sflags.free_found;
              res_slot      <= SLOT_W'(alloc_addr);
              state         <= ST_COMMIT;
            end
          end
        end

        ST_CLEAR: begin
          // Sweep every entry invalid
          if (clr_idx == IDX_W'(ENTRIES - 1)) begin
            if (clr_to_commit) begin
              state <= ST_COMMIT;
            end else if (clr_to_done) begin
              state <= ST_DONE;
            end else begin
              state <= ST_IDLE;
            end
          end else begin
            clr_idx <= clr_idx + 1'b1;
          end
        end

        ST_COMMIT: begin
          state <= ST_DONE;
        end

        ST_DONE: begin
          // Hand the result over once the output register is free
          if (!out_valid || out_ready) begin
            out_valid <= 1'b1;
            hit       <= res_hit;
            slot      <= res_slot;
            replaced  <= res_replaced;
            flushed   <= res_flushed;
            state     <= ST_IDLE;
          end
        end

        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  `include "sector_cache_tag_and_replacement_assert.svh"

  `SCT_ASSERT_IMP(a_no_accept_while_writing, clk, rst, mem_we, !in_ready)
  `SCT_ASSERT_NXT(a_busy_after_accept, clk, rst, accept, !in_ready)
  `SCT_ASSERT_IMP(a_replace_excludes_hit_flush, clk, rst, out_valid && replaced, !hit && !flushed)

endmodule
